>>> design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants for the k-smallest tracker: default sizes and the width
// and reset value of the keep-count register.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int MAX_KEEP_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int              KEEP_COUNT_W     = 5;
    localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RESET = 5'd1;

endpackage

>>> design/kst_insert.sv
// ----------------------------------------------------------------------------
// kst_insert
// Parallel compare-and-insert over the sorted store. Every entry is compared
// with the new sample at once; the thermometer of compare results gives the
// insertion point, and each entry either holds, takes the sample or takes
// its lower neighbour.
// ----------------------------------------------------------------------------
module kst_insert #(
    parameter int MAX_KEEP   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(MAX_KEEP + 1),
    parameter int IW         = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic signed [DATA_WIDTH-1:0] store      [MAX_KEEP],
    input  logic        [CW-1:0]         held,
    input  logic        [CW-1:0]         keep,
    input  logic signed [DATA_WIDTH-1:0] sample,
    output logic signed [DATA_WIDTH-1:0] store_next [MAX_KEEP],
    output logic        [CW-1:0]         held_next
);

    logic [MAX_KEEP-1:0] gt;
    logic [MAX_KEEP-1:0] shift_from;
    logic                room;
    logic                replace;
    logic                take;
    logic [CW-1:0]       base;

    // Entry compares: a set bit means the held value is strictly greater.
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            gt[i] = store[i] > sample;
        end
    end

    assign room    = held < keep;
    assign replace = (keep != '0) && !room && (held != '0) && gt[IW'(held - 1'b1)];
    assign take    = ((keep != '0) && room) || replace;
    assign base    = replace ? held - 1'b1 : held;

    // Entries at or above the live count count as greater, so the sample
    // lands just above the last entry that is not greater than it.
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            shift_from[i] = (CW'(i) >= base) || gt[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            if (!take || !shift_from[i])
            begin
                store_next[i] = store[i];
            end
            else if (i == 0)
            begin
                store_next[i] = sample;
            end
            else if (!shift_from[i-1])
            begin
                store_next[i] = sample;
            end
            else
            begin
                store_next[i] = store[i-1];
            end
        end
    end

    assign held_next = take ? base + 1'b1 : held;

endmodule

>>> design/kst_drain.sv
// ----------------------------------------------------------------------------
// kst_drain
// Output buffer for one run. It takes a snapshot of the sorted store and
// hands the entries out largest first, one item per accepted transfer.
// ----------------------------------------------------------------------------
module kst_drain #(
    parameter int MAX_KEEP   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(MAX_KEEP + 1),
    parameter int IW         = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic signed [DATA_WIDTH-1:0] load_data [MAX_KEEP],
    input  logic        [CW-1:0]         load_cnt,
    output logic                         free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] kept_value,
    output logic                         last_of_run
);

    logic signed [DATA_WIDTH-1:0] buf_reg [MAX_KEEP];
    logic        [CW-1:0]         cnt_reg;
    logic        [CW-1:0]         cnt_next;
    logic                         pop;

    assign out_valid   = cnt_reg != '0;
    assign pop         = out_valid && out_ready;
    assign free        = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && out_ready);
    assign kept_value  = buf_reg[IW'(cnt_reg - 1'b1)];
    assign last_of_run = cnt_reg == CW'(1);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = load_cnt;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= load_data;
        end
    end

endmodule

>>> design/k_smallest_tracker.sv
// ----------------------------------------------------------------------------
// k_smallest_tracker
// Keeps the k smallest signed samples of a set and returns them, largest
// first, when the set ends.
// ----------------------------------------------------------------------------
// Usage. Samples arrive on the input channel (in_valid / in_ready) with
// end_of_set marking the final sample of a set. The block keeps the
// keep_count smallest samples seen so far (capped at MAX_KEEP). When the
// final sample has been taken in, the kept values leave on the output
// channel (out_valid / out_ready), largest first, with last_of_run set on
// the final item of the run. The store is then empty for the next set.
// A keep_count of zero keeps nothing and emits nothing.
//
// Throughput is one input item per cycle while the input is not stalled:
// the whole compare-and-insert across the store is combinational logic
// between the input register and the store. A run drains one result per
// accepted transfer. A final sample passes the input register and then
// the output buffer load before the first result of its run appears.
//
// Samples keep flowing while a run drains. A final sample waits in the
// input register until the previous run has been fully taken, and the
// input stalls behind it. Reset empties the pipeline, the store and the
// output buffer, and sets keep_count to 1. The user must write keep_count through
// cfg_wr_en / cfg_wr_data only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module k_smallest_tracker
    import kst_pkg::*;
#(
    parameter int MAX_KEEP   = MAX_KEEP_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic        [KEEP_COUNT_W-1:0] cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  logic                         end_of_set,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] kept_value,
    output logic                         last_of_run
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic [KEEP_COUNT_W-1:0] keep_count_reg;
    logic [CW-1:0]           keep;

    // Input register.
    logic                         s1_valid_reg;
    logic signed [DATA_WIDTH-1:0] s1_sample_reg;
    logic                         s1_last_reg;
    logic                         s1_fire;

    // Sorted store, ascending; only the first held_reg entries are live.
    logic signed [DATA_WIDTH-1:0] store_reg  [MAX_KEEP];
    logic signed [DATA_WIDTH-1:0] store_next [MAX_KEEP];
    logic        [CW-1:0]         held_reg;
    logic        [CW-1:0]         ins_held;
    logic        [CW-1:0]         emit_cnt;
    logic                         drain_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            keep_count_reg <= cfg_wr_data;
        end
    end

    // A keep count beyond the store size saturates to the store size.
    always_comb
    begin
        if (32'(keep_count_reg) > MAX_KEEP)
        begin
            keep = CW'(MAX_KEEP);
        end
        else
        begin
            keep = CW'(keep_count_reg);
        end
    end

    // A final sample may only move on once the output buffer can take its run.
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || drain_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= end_of_set;
        end
    end

    kst_insert #(
        .MAX_KEEP   (MAX_KEEP),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW),
        .IW         (IW)
    ) u_insert (
        .store      (store_reg),
        .held       (held_reg),
        .keep       (keep),
        .sample     (s1_sample_reg),
        .store_next (store_next),
        .held_next  (ins_held)
    );

    // If keep_count was lowered mid-set, only the smallest entries up to it
    // are emitted.
    assign emit_cnt = (ins_held < keep) ? ins_held : keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (s1_fire)
        begin
            held_reg <= s1_last_reg ? '0 : ins_held;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            store_reg <= store_next;
        end
    end

    kst_drain #(
        .MAX_KEEP   (MAX_KEEP),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW),
        .IW         (IW)
    ) u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire && s1_last_reg),
        .load_data   (store_next),
        .load_cnt    (emit_cnt),
        .free        (drain_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kept_value  (kept_value),
        .last_of_run (last_of_run)
    );

    // The live count never exceeds the store.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(MAX_KEEP))
        else $error("held count beyond store size");

    // The end of a set always leaves the store empty.
    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (held_reg == '0))
        else $error("store not cleared after end of set");

    // A final sample never overwrites a run that is still draining.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg && out_valid) |-> (last_of_run && out_ready))
        else $error("run loaded over an undrained run");

    // Live entries stay in ascending order.
    for (genvar g = 0; g + 1 < MAX_KEEP; g++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (CW'(g + 1) < held_reg) |-> (store_reg[g] <= store_reg[g+1]))
            else $error("store out of order");
    end

endmodule
